// ===== rtl/kpedit_pkg.sv =====
// ----------------------------------------------------------------------------
// kpedit_pkg
// Types and constants for the keypad edge detector and value editor.
// ----------------------------------------------------------------------------
package kpedit_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DOWN_KEY_INDEX   = 2'd0;
    localparam logic [1:0] CFG_UP_KEY_INDEX     = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_TICKS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [3:0]  DOWN_KEY_RESET   = 4'd0;
    localparam logic [3:0]  UP_KEY_RESET     = 4'd1;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd50;

    // Auto-repeat period in ticks once the long-press delay has run out.
    localparam logic [15:0] REPEAT_PERIOD = 16'd5;

    // Direction of the key that is currently held.
    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_DOWN = 2'b01,
        DIR_UP   = 2'b10
    } hold_dir_t;

    typedef struct packed {
        logic [3:0]  down_key_index;
        logic [3:0]  up_key_index;
        logic [15:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic        scan_valid;
        logic [7:0]  scan_byte0;
        logic [7:0]  scan_byte1;
        logic [7:0]  scan_byte2;
        logic [7:0]  scan_byte3;
        logic [15:0] toggle_clear_mask;
        logic [15:0] value_in;
        logic [15:0] value_min;
        logic [15:0] value_max;
    } in_item_t;

    typedef struct packed {
        logic        scan_done;
        logic [15:0] keys_down;
        logic [15:0] keys_pressed;
        logic [15:0] keys_released;
        logic [15:0] keys_toggled;
        logic [15:0] value_out;
    } out_item_t;

    // Remap four raw scan bytes into the key vector. Bits 1 and 4 of each
    // byte form the low byte, bits 0 and 3 form the high byte.
    function automatic logic [15:0] remap_scan(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3
    );
        return {b0[0], b0[3], b1[0], b1[3], b2[0], b2[3], b3[0], b3[3],
                b0[1], b0[4], b1[1], b1[4], b2[1], b2[4], b3[1], b3[4]};
    endfunction

endpackage

// ===== rtl/kpedit_value_editor.sv =====
// ----------------------------------------------------------------------------
// kpedit_value_editor
// Clamps the edited value and steps it while the down or up key is held,
// with a long-press delay followed by a fixed auto-repeat period.
// ----------------------------------------------------------------------------
module kpedit_value_editor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  kpedit_pkg::cfg_t   cfg,
    input  logic [15:0]        key_vec,
    input  logic [15:0]        value_in,
    input  logic [15:0]        value_min,
    input  logic [15:0]        value_max,
    output logic [15:0]        value_out
);

    kpedit_pkg::hold_dir_t held_dir_reg, held_dir_next;
    logic [15:0]           hold_cnt_reg, hold_cnt_next;

    logic [15:0] clamp_lo;
    logic [15:0] clamped;
    logic        down_held;
    logic        up_held;
    logic [15:0] cnt_inc;
    logic        repeat_due;
    logic        step_down;
    logic        step_up;

    // Clamp to the minimum first, then to the maximum.
    assign clamp_lo = (value_in < value_min) ? value_min : value_in;
    assign clamped  = (clamp_lo > value_max) ? value_max : clamp_lo;

    assign down_held  = key_vec[cfg.down_key_index];
    assign up_held    = key_vec[cfg.up_key_index];
    assign cnt_inc    = hold_cnt_reg + 16'd1;
    assign repeat_due = (cnt_inc >= cfg.long_press_ticks);

    // Hold tracking: the first tick of a new direction steps at once; after
    // that the counter runs up to the long-press delay and reloads so that
    // the following steps come one repeat period apart.
    always_comb begin
        held_dir_next = held_dir_reg;
        hold_cnt_next = hold_cnt_reg;
        step_down     = 1'b0;
        step_up       = 1'b0;
        if (down_held) begin
            if (clamped > value_min) begin
                if (held_dir_reg != kpedit_pkg::DIR_DOWN) begin
                    held_dir_next = kpedit_pkg::DIR_DOWN;
                    step_down     = 1'b1;
                end else if (repeat_due) begin
                    hold_cnt_next = cfg.long_press_ticks - kpedit_pkg::REPEAT_PERIOD;
                    step_down     = 1'b1;
                end else begin
                    hold_cnt_next = cnt_inc;
                end
            end
        end else if (up_held) begin
            if (clamped < value_max) begin
                if (held_dir_reg != kpedit_pkg::DIR_UP) begin
                    held_dir_next = kpedit_pkg::DIR_UP;
                    step_up       = 1'b1;
                end else if (repeat_due) begin
                    hold_cnt_next = cfg.long_press_ticks - kpedit_pkg::REPEAT_PERIOD;
                    step_up       = 1'b1;
                end else begin
                    hold_cnt_next = cnt_inc;
                end
            end
        end else begin
            held_dir_next = kpedit_pkg::DIR_NONE;
            hold_cnt_next = 16'd0;
        end
    end

    // Stepped result; the limit checks above keep it inside the range.
    always_comb begin
        value_out = clamped;
        if (step_down) begin
            value_out = clamped - 16'd1;
        end else if (step_up) begin
            value_out = clamped + 16'd1;
        end
    end

    // Hold state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_dir_reg <= kpedit_pkg::DIR_NONE;
            hold_cnt_reg <= 16'd0;
        end else if (step_en) begin
            held_dir_reg <= held_dir_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

endmodule

// ===== rtl/keypad_edge_and_value_editor_core.sv =====
// ----------------------------------------------------------------------------
// keypad_edge_and_value_editor_core
// Key scan remap with pressed, released and toggle vectors, and an up/down
// value editor with long-press auto-repeat.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  -------   ---  -------------------  --------------------------------------
//  s_        in   s_valid / s_ready    s_payload  (kpedit_pkg::in_item_t)
//  m_        out  m_valid / m_ready    m_payload  (kpedit_pkg::out_item_t)
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
//  One transaction per cycle while s_ready is high; its result is registered
//  on acceptance. All key and editor logic sits between the input port
//  and the output register. Reset returns all key vectors and hold state to
//  zero and the registers to their defaults. A second output register (skid)
//  absorbs one result while m_ready is low; s_ready drops while it is full.
//  Configuration writes are taken in every cycle.
//
module keypad_edge_and_value_editor_core (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  kpedit_pkg::in_item_t    s_payload,

    output logic                    m_valid,
    input  logic                    m_ready,
    output kpedit_pkg::out_item_t   m_payload,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_wdata
);

    kpedit_pkg::cfg_t cfg_reg;

    // Key vector; it also serves as the previous scan for edge detection.
    logic [15:0] key_vec_reg, key_vec_next;
    logic [15:0] press_vec_reg, press_vec_next;
    logic [15:0] release_vec_reg, release_vec_next;
    logic [15:0] toggle_vec_reg, toggle_vec_next;

    kpedit_pkg::out_item_t out_reg, skid_reg;
    logic                  out_valid_reg, skid_valid_reg;

    kpedit_pkg::out_item_t result;
    logic [15:0]           scan_now;
    logic [15:0]           toggle_cleared;
    logic [15:0]           edit_value;
    logic                  accept;
    logic                  pop;

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;
    assign pop       = out_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.down_key_index   <= kpedit_pkg::DOWN_KEY_RESET;
            cfg_reg.up_key_index     <= kpedit_pkg::UP_KEY_RESET;
            cfg_reg.long_press_ticks <= kpedit_pkg::LONG_PRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kpedit_pkg::CFG_DOWN_KEY_INDEX:   cfg_reg.down_key_index   <= cfg_wdata[3:0];
                kpedit_pkg::CFG_UP_KEY_INDEX:     cfg_reg.up_key_index     <= cfg_wdata[3:0];
                kpedit_pkg::CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Toggle clear, then scan remap and edge detection.
    always_comb begin
        scan_now = kpedit_pkg::remap_scan(s_payload.scan_byte0, s_payload.scan_byte1,
                                          s_payload.scan_byte2, s_payload.scan_byte3);
        toggle_cleared   = toggle_vec_reg & ~s_payload.toggle_clear_mask;
        key_vec_next     = key_vec_reg;
        press_vec_next   = press_vec_reg;
        release_vec_next = release_vec_reg;
        toggle_vec_next  = toggle_cleared;
        if (s_payload.scan_valid) begin
            key_vec_next     = scan_now;
            press_vec_next   = scan_now & ~key_vec_reg;
            release_vec_next = ~scan_now & key_vec_reg;
            toggle_vec_next  = toggle_cleared ^ (scan_now & ~key_vec_reg);
        end
    end

    kpedit_value_editor u_editor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .cfg       (cfg_reg),
        .key_vec   (key_vec_next),
        .value_in  (s_payload.value_in),
        .value_min (s_payload.value_min),
        .value_max (s_payload.value_max),
        .value_out (edit_value)
    );

    // Result of the current transaction.
    always_comb begin
        result.scan_done     = s_payload.scan_valid;
        result.keys_down     = key_vec_next;
        result.keys_pressed  = press_vec_next;
        result.keys_released = release_vec_next;
        result.keys_toggled  = toggle_vec_next;
        result.value_out     = edit_value;
    end

    // Key state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_vec_reg     <= 16'd0;
            press_vec_reg   <= 16'd0;
            release_vec_reg <= 16'd0;
            toggle_vec_reg  <= 16'd0;
        end else if (accept) begin
            key_vec_reg     <= key_vec_next;
            press_vec_reg   <= press_vec_next;
            release_vec_reg <= release_vec_next;
            toggle_vec_reg  <= toggle_vec_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

`ifndef ASSERT_OFF
    // The skid entry is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register is empty");

    // An accepted transaction always leaves a result to present.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    // A stalled full output register pushes a new result into the skid entry.
    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result lost while the output was stalled");
`endif

endmodule

// ===== verif/keypad_edge_and_value_editor_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_edge_and_value_editor_core_test
// Drives key scan transactions with random idle gaps on both channels. A
// scoreboard keeps its own model of the key vectors and the hold-to-repeat
// editor and checks every result, field by field, in order. Several register
// settings are covered, written only while the block is drained.
// ----------------------------------------------------------------------------
module keypad_edge_and_value_editor_core_test;

    // Scan bits that do not feed the key vector (bits 2, 5, 6 and 7).
    localparam logic [7:0] UNUSED_SCAN_BITS = 8'hE4;
    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;
    // Length of the long receiver hold-off.
    localparam int LONG_HOLD_OFF = 300;

    // Expected-result store and key/editor model.
    class keypad_scoreboard;
        logic [3:0]                 down_idx;
        logic [3:0]                 up_idx;
        logic [15:0]                long_press;
        logic [15:0]                keys_now;
        logic [15:0]                keys_prev;
        logic [15:0]                pressed;
        logic [15:0]                released;
        logic [15:0]                toggled;
        kpedit_pkg::hold_dir_t      held;
        logic [15:0]                hold_count;
        kpedit_pkg::out_item_t      expected_ticks[$];
        int                         mismatches;

        function new();
            down_idx    = kpedit_pkg::DOWN_KEY_RESET;
            up_idx      = kpedit_pkg::UP_KEY_RESET;
            long_press  = kpedit_pkg::LONG_PRESS_RESET;
            keys_now    = '0;
            keys_prev   = '0;
            pressed     = '0;
            released    = '0;
            toggled     = '0;
            held        = kpedit_pkg::DIR_NONE;
            hold_count  = '0;
            mismatches  = 0;
        endfunction

        function void set_register(input logic [1:0] index, input logic [15:0] data);
            case (index)
                kpedit_pkg::CFG_DOWN_KEY_INDEX:   down_idx = data[3:0];
                kpedit_pkg::CFG_UP_KEY_INDEX:     up_idx = data[3:0];
                kpedit_pkg::CFG_LONG_PRESS_TICKS: long_press = data;
                default: ;
            endcase
        endfunction

        // Gather bits 1/4 of each scan byte into the low byte and bits 0/3
        // into the high byte, first byte at the top.
        function logic [15:0] scan_to_keys(input kpedit_pkg::in_item_t it);
            logic [7:0]  b [4];
            logic [15:0] v;
            b[0] = it.scan_byte0;
            b[1] = it.scan_byte1;
            b[2] = it.scan_byte2;
            b[3] = it.scan_byte3;
            v = '0;
            for (int i = 0; i < 4; i++) begin
                v[7 - 2 * i]  = b[i][1];
                v[6 - 2 * i]  = b[i][4];
                v[15 - 2 * i] = b[i][0];
                v[14 - 2 * i] = b[i][3];
            end
            return v;
        endfunction

        // True when the held key steps the value on this tick.
        function bit hold_fires(input kpedit_pkg::hold_dir_t dir);
            if (held != dir) begin
                held = dir;
                return 1'b1;
            end
            hold_count = hold_count + 16'd1;
            if (hold_count >= long_press) begin
                hold_count = long_press - kpedit_pkg::REPEAT_PERIOD;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function kpedit_pkg::out_item_t predict_tick(input kpedit_pkg::in_item_t it);
            kpedit_pkg::out_item_t res;
            logic [15:0]           scan;
            logic [15:0]           val;
            toggled = toggled & ~it.toggle_clear_mask;
            if (it.scan_valid) begin
                scan      = scan_to_keys(it);
                keys_now  = scan;
                pressed   = (keys_prev ^ scan) & scan;
                released  = ~scan & keys_prev;
                toggled   = toggled ^ pressed;
                keys_prev = scan;
            end

            // Clamp to min first, then to max.
            val = it.value_in;
            if (val < it.value_min) val = it.value_min;
            if (val > it.value_max) val = it.value_max;

            // Down has priority; a step is only tried away from the limit.
            if (keys_now[down_idx]) begin
                if (val > it.value_min && hold_fires(kpedit_pkg::DIR_DOWN))
                    val = val - 16'd1;
            end else if (keys_now[up_idx]) begin
                if (val < it.value_max && hold_fires(kpedit_pkg::DIR_UP))
                    val = val + 16'd1;
            end else begin
                held       = kpedit_pkg::DIR_NONE;
                hold_count = '0;
            end

            res.scan_done     = it.scan_valid;
            res.keys_down     = keys_now;
            res.keys_pressed  = pressed;
            res.keys_released = released;
            res.keys_toggled  = toggled;
            res.value_out     = val;
            return res;
        endfunction

        function void note_scan_item(input kpedit_pkg::in_item_t it);
            expected_ticks.push_back(predict_tick(it));
        endfunction

        function void report(input string what, input logic [15:0] want, input logic [15:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        endfunction

        function void check_tick_result(input kpedit_pkg::out_item_t got);
            kpedit_pkg::out_item_t want;
            if (expected_ticks.size() == 0) begin
                report("result with no transaction outstanding:", '0, got.value_out);
                return;
            end
            want = expected_ticks.pop_front();
            if (got.scan_done !== want.scan_done)
                report("scan_done", 16'(want.scan_done), 16'(got.scan_done));
            if (got.keys_down !== want.keys_down)
                report("keys_down", want.keys_down, got.keys_down);
            if (got.keys_pressed !== want.keys_pressed)
                report("keys_pressed", want.keys_pressed, got.keys_pressed);
            if (got.keys_released !== want.keys_released)
                report("keys_released", want.keys_released, got.keys_released);
            if (got.keys_toggled !== want.keys_toggled)
                report("keys_toggled", want.keys_toggled, got.keys_toggled);
            if (got.value_out !== want.value_out)
                report("value_out", want.value_out, got.value_out);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    kpedit_pkg::in_item_t  s_payload;
    logic                  m_valid;
    logic                  m_ready;
    kpedit_pkg::out_item_t m_payload;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_wdata;

    keypad_scoreboard board;
    bit          no_idle;
    int          hold_off_orders;
    int          hold_off_served;
    int          rx_wait;
    int          quiet_cycles;

    keypad_edge_and_value_editor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always #10 aclk = ~aclk;

    // Idle gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build an input transaction whose scan bytes carry the given key vector.
    // Bits that do not reach the key vector get random noise.
    function automatic kpedit_pkg::in_item_t make_item(
        input logic        valid,
        input logic [15:0] keys,
        input logic [15:0] clr,
        input logic [15:0] val,
        input logic [15:0] vmin,
        input logic [15:0] vmax
    );
        kpedit_pkg::in_item_t it;
        logic [7:0]           b [4];
        for (int i = 0; i < 4; i++) begin
            if (valid) begin
                b[i] = 8'($urandom) & UNUSED_SCAN_BITS;
                b[i][1] = keys[7 - 2 * i];
                b[i][4] = keys[6 - 2 * i];
                b[i][0] = keys[15 - 2 * i];
                b[i][3] = keys[14 - 2 * i];
            end else begin
                b[i] = 8'($urandom);
            end
        end
        it.scan_valid        = valid;
        it.scan_byte0        = b[0];
        it.scan_byte1        = b[1];
        it.scan_byte2        = b[2];
        it.scan_byte3        = b[3];
        it.toggle_clear_mask = clr;
        it.value_in          = val;
        it.value_min         = vmin;
        it.value_max         = vmax;
        return it;
    endfunction

    // One random tick around the key pattern currently held.
    function automatic kpedit_pkg::in_item_t random_tick(input logic [15:0] keys);
        logic [15:0] clr;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] val;
        int          r;
        // Occasionally a scan that breaks the held pattern.
        if ($urandom_range(0, 99) < 10) keys = 16'($urandom);

        r = $urandom_range(0, 99);
        clr = (r < 70) ? 16'h0000 : (r < 90) ? 16'($urandom) : 16'hFFFF;

        lo = 16'($urandom);
        hi = lo + 16'($urandom_range(2, 2000));
        if (hi < lo) hi = 16'hFFFF;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            val = 16'($urandom_range(lo, hi));
        end else if (r < 85) begin
            val = $urandom_range(0, 1) ? lo : hi;
        end else begin
            val = 16'($urandom);
            lo  = 16'($urandom);
            hi  = 16'($urandom);
        end
        return make_item($urandom_range(0, 99) < 60, keys, clr, val, lo, hi);
    endfunction

    // Offer one transaction and wait until it is taken.
    task automatic send_item(input kpedit_pkg::in_item_t item, input int gap);
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_scan_item(item);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_ticks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_register(index, data);
    endtask

    // One register setting followed by random ticks built from held-key runs.
    task automatic run_phase(input logic [3:0] down_k, input logic [3:0] up_k,
                             input logic [15:0] lp, input int count,
                             input bit with_hold_off, input bit with_pause);
        logic [15:0] held_keys;
        int          run_left;
        write_register(kpedit_pkg::CFG_DOWN_KEY_INDEX, {12'd0, down_k});
        write_register(kpedit_pkg::CFG_UP_KEY_INDEX, {12'd0, up_k});
        write_register(kpedit_pkg::CFG_LONG_PRESS_TICKS, lp);
        held_keys = '0;
        run_left  = 0;
        for (int n = 0; n < count; n++) begin
            no_idle = ((n / 85) % 3 == 1);
            if (run_left == 0) begin
                run_left = $urandom_range(1, 100);
                case ($urandom_range(0, 5))
                    0: held_keys = '0;
                    1: held_keys = 16'd1 << down_k;
                    2: held_keys = 16'd1 << up_k;
                    3: held_keys = (16'd1 << down_k) | (16'd1 << up_k);
                    4: held_keys = (16'd1 << up_k) | (16'd1 << $urandom_range(0, 15));
                    default: held_keys = 16'($urandom);
                endcase
            end
            run_left--;
            if (with_hold_off && n == 60) hold_off_orders++;
            if (with_pause && n == count / 2) drain();
            send_item(random_tick(held_keys), pick_gap());
        end
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_tick_result(m_payload);
        if (hold_off_served != hold_off_orders) begin
            hold_off_served = hold_off_orders;
            rx_wait = LONG_HOLD_OFF;
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            rx_wait = pick_gap();
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        logic [15:0] kd;
        logic [15:0] ku;
        board           = new();
        no_idle         = 1'b0;
        hold_off_orders = 0;
        hold_off_served = 0;
        rx_wait         = 0;
        quiet_cycles    = 0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_payload       = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = kpedit_pkg::CFG_DOWN_KEY_INDEX;
        cfg_wdata       = '0;
        kd = 16'd1 << kpedit_pkg::DOWN_KEY_RESET;
        ku = 16'd1 << kpedit_pkg::UP_KEY_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ticks under the reset register values.
        send_item(make_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), pick_gap());
        send_item(make_item(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF), pick_gap());
        // Editor keeps running on the stored keys while no scan comes in.
        for (int i = 0; i < 4; i++)
            send_item(make_item(1'b0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF),
                      pick_gap());
        send_item(make_item(1'b1, 16'h0000, 16'hFFFF, 16'd300, 16'd100, 16'd200), pick_gap());
        // Down held at the lower limit, then above it.
        send_item(make_item(1'b1, kd, 16'h0000, 16'd100, 16'd100, 16'd200), pick_gap());
        send_item(make_item(1'b1, kd, 16'h0000, 16'd150, 16'd100, 16'd200), pick_gap());
        // Direct switch from down to up, then up at the upper limit.
        send_item(make_item(1'b1, ku, 16'h0000, 16'd150, 16'd100, 16'd200), pick_gap());
        send_item(make_item(1'b1, ku, 16'h0000, 16'd200, 16'd100, 16'd200), pick_gap());
        send_item(make_item(1'b0, ku, 16'h0000, 16'd50, 16'd100, 16'd200), pick_gap());
        // Minimum above maximum with each key.
        send_item(make_item(1'b1, ku, 16'h0000, 16'd500, 16'd600, 16'd400), pick_gap());
        send_item(make_item(1'b1, kd, 16'h0000, 16'd500, 16'd600, 16'd400), pick_gap());
        // Both keys down: down wins.
        send_item(make_item(1'b1, kd | ku, 16'h0000, 16'd1000, 16'd0, 16'hFFFF), pick_gap());
        send_item(make_item(1'b1, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap());
        send_item(make_item(1'b1, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000), pick_gap());
        send_item(make_item(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000), pick_gap());
        send_item(make_item(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF), pick_gap());
        send_item(make_item(1'b1, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'hFFFF), pick_gap());

        // Random phases across register settings, extremes included.
        run_phase(kpedit_pkg::DOWN_KEY_RESET, kpedit_pkg::UP_KEY_RESET,
                  kpedit_pkg::LONG_PRESS_RESET, 255, 1'b0, 1'b0);
        run_phase(4'd0, 4'd0, 16'd5, 255, 1'b1, 1'b0);
        run_phase(4'd15, 4'd15, 16'hFFFF, 255, 1'b0, 1'b0);
        run_phase(4'd15, 4'd0, 16'd12, 255, 1'b0, 1'b1);
        run_phase(4'($urandom), 4'($urandom), 16'($urandom_range(5, 40)), 255, 1'b0, 1'b0);
        run_phase(4'($urandom), 4'($urandom), 16'($urandom_range(5, 120)), 255, 1'b0, 1'b0);

        drain();
        repeat (5) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_ticks.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
